// ===== rtl/core/rdzr_pkg.sv =====
// Shared constants and types for the radial dead zone rescaler.
package rdzr_pkg;

   // Q1.15 full scale, meaning 1.0
   localparam logic [14:0] FULL_SCALE = 15'h7FFF;

   localparam int unsigned FIELD_W    = 16;
   localparam int unsigned NUM_FIELDS = 6;
   localparam int unsigned DATA_W     = FIELD_W * NUM_FIELDS;
   localparam int unsigned SQRT_STEPS = 16;
   localparam int unsigned DIV_STEPS  = 15;
   localparam int unsigned SQ_W       = 32;
   localparam int unsigned SCALE_W    = 30;
   localparam int unsigned DEN_W      = 31;
   localparam int unsigned NUM_W      = 46;

   // register reset values
   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
   localparam logic [14:0] TRIG_TH_RESET  = 15'd30;

   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_TH  = 2'd2
   } csr_index_type;

   // stick magnitudes and signs carried through the square root
   typedef struct packed {
      logic [15:0] ax;
      logic [15:0] ay;
      logic        nx;
      logic        ny;
   } stick_type;

   // trigger excess over threshold
   typedef struct packed {
      logic [14:0] diff;
      logic        neg;
      logic        zero;
   } trig_type;

   // per-output sign and force-to-zero flags
   typedef struct packed {
      logic neg;
      logic zero;
   } lane_type;

endpackage

// ===== rtl/core/radial_dead_zone_rescaler.sv =====
// Radial dead zone rescaler: 36-stage pipeline, one sample per cycle unless rsp is stalled.
// Stages from request accept to rsp_tvalid: 1 capture, 1 square,
// 16 square-root steps, 2 multiply, 15 divide steps, 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while rsp is stalled.
// Reset: synchronous, active high; clears the valid bits and loads the
// default dead zones (7849, 8689) and trigger threshold (30).
module radial_dead_zone_rescaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_x, left_y, right_x, right_y, left_trig, right_trig (16b each, from bit 0)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_left_x, out_left_y, out_right_x, out_right_y, out_left_trig,
   // out_right_trig (16b each, from bit 0)
   output logic [95:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   localparam int unsigned NSTG  = rdzr_pkg::SQRT_STEPS + rdzr_pkg::DIV_STEPS + 5;
   localparam int unsigned NL    = rdzr_pkg::NUM_FIELDS;

   // configuration registers
   logic [14:0] dz_ff [0:1];
   logic [14:0] th_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff[0] <= rdzr_pkg::LEFT_DZ_RESET;
         dz_ff[1] <= rdzr_pkg::RIGHT_DZ_RESET;
         th_ff    <= rdzr_pkg::TRIG_TH_RESET;
      end else if (csr_valid) begin
         case (rdzr_pkg::csr_index_type'(csr_index))
            rdzr_pkg::CSR_LEFT_DZ:  dz_ff[0] <= csr_data;
            rdzr_pkg::CSR_RIGHT_DZ: dz_ff[1] <= csr_data;
            rdzr_pkg::CSR_TRIG_TH:  th_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and valid shift line
   logic            adv;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: capture request
   logic [rdzr_pkg::DATA_W-1:0] raw_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ff <= req_tdata;
      end
   end

   // stage 1: absolute values, sum of squares, trigger threshold
   rdzr_pkg::stick_type           stk1_in [0:1];
   rdzr_pkg::stick_type           stk1_ff [0:1];
   logic [rdzr_pkg::SQ_W-1:0]     sum1_in [0:1];
   logic [rdzr_pkg::SQ_W-1:0]     sum1_ff [0:1];
   rdzr_pkg::trig_type            trg1_in [0:1];
   rdzr_pkg::trig_type            trg1_ff [0:1];

   always_comb begin
      logic [15:0] x, y, t, at;
      logic [14:0] a;
      for (int k = 0; k < 2; k++) begin
         x = raw_ff[32*k +: 16];
         y = raw_ff[32*k+16 +: 16];
         stk1_in[k].nx = x[15];
         stk1_in[k].ny = y[15];
         stk1_in[k].ax = x[15] ? 16'(-x) : x;
         stk1_in[k].ay = y[15] ? 16'(-y) : y;
         sum1_in[k] = {16'b0, stk1_in[k].ax} * {16'b0, stk1_in[k].ax}
                    + {16'b0, stk1_in[k].ay} * {16'b0, stk1_in[k].ay};
      end
      for (int j = 0; j < 2; j++) begin
         t  = raw_ff[64+16*j +: 16];
         at = t[15] ? 16'(-t) : t;
         a  = (at > {1'b0, rdzr_pkg::FULL_SCALE}) ? rdzr_pkg::FULL_SCALE : at[14:0];
         trg1_in[j].neg  = t[15];
         trg1_in[j].zero = (th_ff >= rdzr_pkg::FULL_SCALE) || (a < th_ff);
         trg1_in[j].diff = a - th_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stk1_ff <= stk1_in;
         sum1_ff <= sum1_in;
         trg1_ff <= trg1_in;
      end
   end

   // square root: one result bit per stage
   logic [rdzr_pkg::SQ_W-1:0] srem_ff  [0:rdzr_pkg::SQRT_STEPS-1][0:1];
   logic [rdzr_pkg::SQ_W-1:0] sroot_ff [0:rdzr_pkg::SQRT_STEPS-1][0:1];
   rdzr_pkg::stick_type       sstk_ff  [0:rdzr_pkg::SQRT_STEPS-1][0:1];
   rdzr_pkg::trig_type        strg_ff  [0:rdzr_pkg::SQRT_STEPS-1][0:1];

   for (genvar i = 0; i < rdzr_pkg::SQRT_STEPS; i++) begin : g_sqrt
      localparam logic [rdzr_pkg::SQ_W-1:0] SBIT = 32'h4000_0000 >> (2*i);
      logic [rdzr_pkg::SQ_W-1:0] rem_src  [0:1];
      logic [rdzr_pkg::SQ_W-1:0] root_src [0:1];
      logic [rdzr_pkg::SQ_W-1:0] rem_in   [0:1];
      logic [rdzr_pkg::SQ_W-1:0] root_in  [0:1];
      rdzr_pkg::stick_type       stk_src  [0:1];
      rdzr_pkg::trig_type        trg_src  [0:1];

      if (i == 0) begin : g_first
         assign rem_src  = sum1_ff;
         assign root_src = '{default: '0};
         assign stk_src  = stk1_ff;
         assign trg_src  = trg1_ff;
      end else begin : g_next
         assign rem_src  = srem_ff[i-1];
         assign root_src = sroot_ff[i-1];
         assign stk_src  = sstk_ff[i-1];
         assign trg_src  = strg_ff[i-1];
      end

      always_comb begin
         logic [rdzr_pkg::SQ_W-1:0] trial;
         for (int k = 0; k < 2; k++) begin
            trial = root_src[k] + SBIT;
            if (rem_src[k] >= trial) begin
               rem_in[k]  = rem_src[k] - trial;
               root_in[k] = (root_src[k] >> 1) + SBIT;
            end else begin
               rem_in[k]  = rem_src[k];
               root_in[k] = root_src[k] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[i]  <= rem_in;
            sroot_ff[i] <= root_in;
            sstk_ff[i]  <= stk_src;
            strg_ff[i]  <= trg_src;
         end
      end
   end

   // first multiply stage: scale and denominators
   localparam int unsigned SL = rdzr_pkg::SQRT_STEPS - 1;

   logic [rdzr_pkg::SCALE_W-1:0] scale_in [0:1];
   logic [rdzr_pkg::SCALE_W-1:0] scale_ff [0:1];
   logic [rdzr_pkg::DEN_W-1:0]   sden_in  [0:1];
   logic [rdzr_pkg::DEN_W-1:0]   sden_ff  [0:1];
   logic [15:0]                  mag_in   [0:3];
   logic [15:0]                  mag_ff   [0:3];
   logic [rdzr_pkg::SCALE_W-1:0] tnum_in  [0:1];
   logic [rdzr_pkg::SCALE_W-1:0] tnum_ff  [0:1];
   logic [14:0]                  tden_in;
   logic [14:0]                  tden_ff;
   rdzr_pkg::lane_type           lane1_in [0:NL-1];
   rdzr_pkg::lane_type           lane1_ff [0:NL-1];

   always_comb begin
      logic [15:0] m;
      logic [14:0] mc;
      logic        z;
      for (int k = 0; k < 2; k++) begin
         m  = sroot_ff[SL][k][15:0];
         mc = (m > {1'b0, rdzr_pkg::FULL_SCALE}) ? rdzr_pkg::FULL_SCALE : m[14:0];
         z  = (dz_ff[k] >= rdzr_pkg::FULL_SCALE) || (m == 16'd0)
              || (m < {1'b0, dz_ff[k]});
         scale_in[k] = {15'b0, 15'(mc - dz_ff[k])} * {15'b0, rdzr_pkg::FULL_SCALE};
         sden_in[k]  = {15'b0, m} * {16'b0, 15'(rdzr_pkg::FULL_SCALE - dz_ff[k])};
         mag_in[2*k]      = sstk_ff[SL][k].ax;
         mag_in[2*k+1]    = sstk_ff[SL][k].ay;
         lane1_in[2*k]    = '{neg: sstk_ff[SL][k].nx, zero: z};
         lane1_in[2*k+1]  = '{neg: sstk_ff[SL][k].ny, zero: z};
      end
      for (int j = 0; j < 2; j++) begin
         tnum_in[j] = {15'b0, strg_ff[SL][j].diff} * {15'b0, rdzr_pkg::FULL_SCALE};
         lane1_in[4+j] = '{neg: strg_ff[SL][j].neg, zero: strg_ff[SL][j].zero};
      end
      tden_in = rdzr_pkg::FULL_SCALE - th_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scale_ff <= scale_in;
         sden_ff  <= sden_in;
         mag_ff   <= mag_in;
         tnum_ff  <= tnum_in;
         tden_ff  <= tden_in;
         lane1_ff <= lane1_in;
      end
   end

   // second multiply stage: stick dividends
   logic [rdzr_pkg::NUM_W-1:0] num2_in  [0:NL-1];
   logic [rdzr_pkg::NUM_W-1:0] num2_ff  [0:NL-1];
   logic [rdzr_pkg::DEN_W-1:0] den2_in  [0:NL-1];
   logic [rdzr_pkg::DEN_W-1:0] den2_ff  [0:NL-1];
   rdzr_pkg::lane_type         lane2_ff [0:NL-1];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         num2_in[l] = {30'b0, mag_ff[l]} * {16'b0, scale_ff[l/2]};
         den2_in[l] = sden_ff[l/2];
      end
      for (int j = 0; j < 2; j++) begin
         num2_in[4+j] = {16'b0, tnum_ff[j]};
         den2_in[4+j] = {16'b0, tden_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num2_ff  <= num2_in;
         den2_ff  <= den2_in;
         lane2_ff <= lane1_ff;
      end
   end

   // restoring divide: one quotient bit per stage, quotient never above full scale
   logic [rdzr_pkg::NUM_W-1:0] drem_ff  [0:rdzr_pkg::DIV_STEPS-1][0:NL-1];
   logic [rdzr_pkg::DEN_W-1:0] dden_ff  [0:rdzr_pkg::DIV_STEPS-1][0:NL-1];
   logic [14:0]                dq_ff    [0:rdzr_pkg::DIV_STEPS-1][0:NL-1];
   rdzr_pkg::lane_type         dlane_ff [0:rdzr_pkg::DIV_STEPS-1][0:NL-1];

   for (genvar j = 0; j < rdzr_pkg::DIV_STEPS; j++) begin : g_div
      localparam int unsigned SH = rdzr_pkg::DIV_STEPS - 1 - j;
      logic [rdzr_pkg::NUM_W-1:0] rem_src [0:NL-1];
      logic [rdzr_pkg::DEN_W-1:0] den_src [0:NL-1];
      logic [14:0]                q_src   [0:NL-1];
      rdzr_pkg::lane_type         lane_src[0:NL-1];
      logic [rdzr_pkg::NUM_W-1:0] rem_in  [0:NL-1];
      logic [14:0]                q_in    [0:NL-1];

      if (j == 0) begin : g_first
         assign rem_src  = num2_ff;
         assign den_src  = den2_ff;
         assign q_src    = '{default: '0};
         assign lane_src = lane2_ff;
      end else begin : g_next
         assign rem_src  = drem_ff[j-1];
         assign den_src  = dden_ff[j-1];
         assign q_src    = dq_ff[j-1];
         assign lane_src = dlane_ff[j-1];
      end

      always_comb begin
         logic [rdzr_pkg::NUM_W-1:0] sub;
         for (int l = 0; l < NL; l++) begin
            sub = {15'b0, den_src[l]} << SH;
            if (rem_src[l] >= sub) begin
               rem_in[l] = rem_src[l] - sub;
               q_in[l]   = {q_src[l][13:0], 1'b1};
            end else begin
               rem_in[l] = rem_src[l];
               q_in[l]   = {q_src[l][13:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[j]  <= rem_in;
            dden_ff[j]  <= den_src;
            dq_ff[j]    <= q_in;
            dlane_ff[j] <= lane_src;
         end
      end
   end

   // output register: apply sign and zeroing
   localparam int unsigned DL = rdzr_pkg::DIV_STEPS - 1;

   logic [rdzr_pkg::DATA_W-1:0] out_in;
   logic [rdzr_pkg::DATA_W-1:0] out_ff;

   always_comb begin
      logic [15:0] q;
      for (int l = 0; l < NL; l++) begin
         q = {1'b0, dq_ff[DL][l]};
         if (dlane_ff[DL][l].zero) begin
            out_in[16*l +: 16] = 16'd0;
         end else if (dlane_ff[DL][l].neg) begin
            out_in[16*l +: 16] = 16'(-q);
         end else begin
            out_in[16*l +: 16] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = out_ff;

endmodule

// ===== rtl/core/rdzr_checker.sv =====
// Port-level checks for the radial dead zone rescaler, bound to the top level.
module rdzr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [14:0] csr_data
);

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // the pipeline takes a request whenever the output is free
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request refused with free output");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response straight after reset");

   // outputs stay within plus or minus full scale
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] != 16'h8000) && (rsp_tdata[31:16] != 16'h8000)
         && (rsp_tdata[47:32] != 16'h8000) && (rsp_tdata[63:48] != 16'h8000)
         && (rsp_tdata[79:64] != 16'h8000) && (rsp_tdata[95:80] != 16'h8000))
      else $error("output beyond full scale");

   // configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind radial_dead_zone_rescaler rdzr_checker u_rdzr_checker (.*);

// ===== bench/radial_dead_zone_rescaler_tb.sv =====
// Self-checking testbench for the radial dead zone rescaler.
module radial_dead_zone_rescaler_tb;

   localparam int FS        = 32767;
   localparam int LATENCY   = 36;
   localparam int WD_LIMIT  = 4000;
   localparam int LONG_HOLD = 200;

   typedef struct packed {
      logic signed [15:0] rt;
      logic signed [15:0] lt;
      logic signed [15:0] ry;
      logic signed [15:0] rx;
      logic signed [15:0] ly;
      logic signed [15:0] lx;
   } sample_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   radial_dead_zone_rescaler DUT (.*);

   // clock generation
   initial begin
      forever #4 clock = ~clock;
   end

   sample_type pending_samples[$];
   sample_type corrected_expected[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   bit hold_req = 0;
   bit hold_taken = 0;
   int quiet_cycles = 0;
   bit stim_done = 0;

   // predictor copy of the registers
   int unsigned dz_left, dz_right, trig_th;

   function automatic int unsigned sqrt_floor(longint unsigned s);
      longint unsigned r;
      r = 0;
      for (int b = 15; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s) r |= 64'd1 << b;
      return int'(r);
   endfunction

   function automatic logic signed [15:0] signed_sat(bit neg, longint unsigned q);
      if (q > FS) q = FS;
      return neg ? -16'(q) : 16'(q);
   endfunction

   function automatic void rescale_stick(input int x, input int y, input int unsigned dz,
                                         output logic signed [15:0] ox,
                                         output logic signed [15:0] oy);
      longint unsigned ax, ay, m, mc, scale, den;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = sqrt_floor(ax * ax + ay * ay);
      mc = m > FS ? FS : m;
      ox = '0;
      oy = '0;
      if (dz >= FS || m == 0 || m < dz) return;
      scale = (mc - dz) * FS;
      den = m * (FS - dz);
      ox = signed_sat(x < 0, ax * scale / den);
      oy = signed_sat(y < 0, ay * scale / den);
   endfunction

   function automatic logic signed [15:0] rescale_trigger(int t, int unsigned th);
      longint unsigned a;
      a = t < 0 ? -t : t;
      if (a > FS) a = FS;
      if (th >= FS || a < th) return '0;
      return signed_sat(t < 0, (a - th) * FS / (FS - th));
   endfunction

   function automatic sample_type correct_sample(sample_type s);
      sample_type r;
      rescale_stick(s.lx, s.ly, dz_left, r.lx, r.ly);
      rescale_stick(s.rx, s.ry, dz_right, r.rx, r.ry);
      r.lt = rescale_trigger(s.lt, trig_th);
      r.rt = rescale_trigger(s.rt, trig_th);
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            sample_type s;
            s = pending_samples.pop_front();
            corrected_expected.push_back(correct_sample(s));
            req_tdata <= s;
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // response side stall control, including one long hold
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else if (hold_req && !hold_taken) begin
         hold_cycles <= LONG_HOLD;
         hold_taken <= 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sample_type got, want;
         got = rsp_tdata;
         if (corrected_expected.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            want = corrected_expected.pop_front();
            if (got.lx !== want.lx) report_mismatch("out_left_x", got.lx, want.lx);
            if (got.ly !== want.ly) report_mismatch("out_left_y", got.ly, want.ly);
            if (got.rx !== want.rx) report_mismatch("out_right_x", got.rx, want.rx);
            if (got.ry !== want.ry) report_mismatch("out_right_y", got.ry, want.ry);
            if (got.lt !== want.lt) report_mismatch("out_left_trig", got.lt, want.lt);
            if (got.rt !== want.rt) report_mismatch("out_right_trig", got.rt, want.rt);
         end
      end
   end

   // watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || stim_done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(rdzr_pkg::csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= 15'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         rdzr_pkg::CSR_LEFT_DZ:  dz_left  = val;
         rdzr_pkg::CSR_RIGHT_DZ: dz_right = val;
         rdzr_pkg::CSR_TRIG_TH:  trig_th  = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_samples.size() > 0 || corrected_expected.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis;
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom_range(400)) - 16'sd200;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random(int n);
      sample_type s;
      repeat (n) begin
         s.lx = rand_axis(); s.ly = rand_axis();
         s.rx = rand_axis(); s.ry = rand_axis();
         s.lt = rand_axis(); s.rt = rand_axis();
         pending_samples.push_back(s);
      end
   endtask

   task automatic add_same(logic signed [15:0] v);
      pending_samples.push_back({6{v}});
   endtask

   initial begin
      dz_left = 7849; dz_right = 8689; trig_th = 30;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed extremes under reset settings
      add_same(16'sh8000); add_same(16'sh7FFF); add_same(16'sd0); add_same(-16'sd1);
      add_same(16'sh8001); add_same(16'sd7849); add_same(16'sd7848);
      add_same(16'sd30); add_same(16'sd29); add_same(-16'sd30);
      pending_samples.push_back({16'sd100, -16'sd100, 16'sh7FFF, 16'sh8000,
                                 16'sh8000, 16'sh7FFF});
      drain();

      // zero thresholds: zero magnitude and extreme inputs
      write_reg(rdzr_pkg::CSR_LEFT_DZ, 0); write_reg(rdzr_pkg::CSR_RIGHT_DZ, 0);
      write_reg(rdzr_pkg::CSR_TRIG_TH, 0);
      add_same(16'sd0); add_same(16'sd1); add_same(-16'sd1); add_same(16'sh8000);
      add_same(16'sh7FFF);
      drain();

      // thresholds at the top of their range
      write_reg(rdzr_pkg::CSR_LEFT_DZ, 32766); write_reg(rdzr_pkg::CSR_RIGHT_DZ, 32766);
      write_reg(rdzr_pkg::CSR_TRIG_TH, 32766);
      add_same(16'sh7FFF); add_same(16'sh8000); add_same(16'sh7FFE); add_same(16'sd23170);
      drain();

      // random phases with different idling profiles and settings
      for (int ph = 0; ph < 3; ph++) begin
         write_reg(rdzr_pkg::CSR_LEFT_DZ, $urandom_range(32766));
         write_reg(rdzr_pkg::CSR_RIGHT_DZ, $urandom_range(20000));
         write_reg(rdzr_pkg::CSR_TRIG_TH, $urandom_range(32766));
         send_idle_pct = ph == 0 ? 8 : ph == 1 ? 71 : 0;
         recv_idle_pct = ph == 0 ? 71 : ph == 1 ? 8 : 0;
         add_random(430);
         if (ph == 2) begin
            @(posedge clock);
            hold_req = 1;
         end
         drain();
      end

      stim_done = 1;
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== radial_dead_zone_rescaler.f =====
rtl/core/rdzr_pkg.sv
rtl/core/radial_dead_zone_rescaler.sv
rtl/core/rdzr_checker.sv
bench/radial_dead_zone_rescaler_tb.sv
